// ===== rtl/prq_pkg.sv =====
// prq_pkg: sizes, status and operation codes and slot helpers for the packet ring queue
// no dependencies; imported by packet_ring_queue_unit, packet_ring_queue_checker and packet_ring_queue_unit_test
`timescale 1ns / 1ps

package prq_pkg;

	// queue geometry
	localparam int QUEUE_SLOTS      = 128;
	localparam int MAX_PACKET_BYTES = 16;
	localparam int SLOT_W           = $clog2(QUEUE_SLOTS);
	localparam int OFF_W            = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
	localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);
	localparam int BYTE_DEPTH       = QUEUE_SLOTS * MAX_PACKET_BYTES;
	localparam int BYTE_ADDR_W      = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [OFF_W-1:0]       off_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [BYTE_ADDR_W-1:0] byte_addr_t;

	// operation codes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_PURGE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_QUEUED   = 3'd0;
	localparam logic [2:0] ST_TOO_LONG = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_BYTE     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_DROPPED  = 3'd5;

	// next slot around the ring
	function automatic slot_t slot_advance(input slot_t idx);
		slot_t res;
		if (idx == slot_t'(QUEUE_SLOTS - 1)) begin
			res = '0;
		end else begin
			res = idx + 1'b1;
		end
		return res;
	endfunction

	// byte memory address of a byte within a slot
	function automatic byte_addr_t byte_addr(input slot_t slot, input off_t off);
		return byte_addr_t'(slot) * byte_addr_t'(MAX_PACKET_BYTES) + byte_addr_t'(off);
	endfunction

endpackage

// ===== rtl/prq_ram.sv =====
// prq_ram: generic single-write, single-read memory with a registered read port
// no dependencies; used for the byte and length stores of the packet ring queue
`timescale 1ns / 1ps

module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read, read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/packet_ring_queue_unit.sv =====
// packet_ring_queue_unit: ring queue of short packets held in two synchronous memories
// depends on prq_pkg and prq_ram
`timescale 1ns / 1ps

// Usage
// Input words on s_*: s_tuser selects push, pop or purge; a push carries one packet
// byte in s_tdata and s_tlast marks the final byte of the packet. Output words on m_*:
// m_tuser is the status, m_tdata holds the popped byte and the queue-full flag, and
// m_tlast marks the last word caused by one input word.
// A push of a final byte puts its status word into the output register at the same edge
// that accepts it. A pop of a nonempty queue reads the length memory, then reads the
// first byte from the byte memory, then streams one byte per cycle while the output
// register is free, bounded by the single read port of the byte memory. Purge results
// and empty reports are loaded into the output register at the edge that accepts them.
// One input word is processed at a time; s_tready is low while a pop streams out.
// The output register frees while its word is taken, so a new word is accepted in the
// same cycle the previous result leaves. When a waiting word is not taken the pop stream
// pauses and the byte memory read data is held until the word can be loaded.
// Reset clears the ring indices, the partial-packet count and the overlong flag; the
// memories need no clearing since only committed slots are ever read.

module packet_ring_queue_unit
	import prq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] operation
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] queue_full, [15:9] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast    // end_of_packet
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LEN   = 2'd1;
	localparam logic [1:0] S_BYTES = 2'd2;

	logic [1:0] state_q;
	slot_t      wr_idx_q;
	slot_t      rd_idx_q;
	slot_t      base_q;
	len_t       pend_q;
	logic       over_q;
	len_t       len_q;
	off_t       off_q;
	logic       full_q;

	logic       m_valid_q;
	logic [2:0] m_status_q;
	logic [7:0] m_byte_q;
	logic       m_last_q;
	logic       m_full_q;

	logic       out_free;
	logic       out_load;
	logic       acc;
	logic       room;
	logic       over_next;
	logic       full_now;
	logic       is_empty;
	logic       byte_last;
	logic       byte_we;
	byte_addr_t byte_waddr;
	logic       byte_re;
	byte_addr_t byte_raddr;
	logic [7:0] byte_rdata;
	logic       len_we;
	len_t       len_wdata;
	logic       len_re;
	len_t       len_rdata;

	// handshake
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	// ring status
	assign room      = (pend_q < len_t'(MAX_PACKET_BYTES));
	assign over_next = over_q || !room;
	assign full_now  = (slot_advance(wr_idx_q) == rd_idx_q);
	assign is_empty  = (wr_idx_q == rd_idx_q);
	assign byte_last = ((len_t'(off_q) + 1'b1) == len_q);

	// output register load: status words, empty reports and popped bytes
	assign out_load = (acc && ((s_tuser == OP_PUSH && s_tlast) ||
		(s_tuser == OP_POP && is_empty) || s_tuser == OP_PURGE)) ||
		(state_q == S_BYTES && out_free);

	// store writes of a push
	assign byte_we    = acc && (s_tuser == OP_PUSH) && room;
	assign byte_waddr = byte_addr(wr_idx_q, off_t'(pend_q));
	assign len_we     = acc && (s_tuser == OP_PUSH) && s_tlast && !over_next && !full_now;
	assign len_wdata  = pend_q + 1'b1;

	// length read at the head slot when a pop starts
	assign len_re = acc && (s_tuser == OP_POP) && !is_empty;

	// byte reads of a pop, one ahead of the output register
	always_comb begin
		byte_re    = 1'b0;
		byte_raddr = byte_addr(base_q, '0);
		if (state_q == S_LEN) begin
			byte_re = 1'b1;
		end else if (state_q == S_BYTES && out_free && !byte_last) begin
			byte_re    = 1'b1;
			byte_raddr = byte_addr(base_q, off_t'(off_q + 1'b1));
		end
	end

	prq_ram #(
		.WIDTH(8),
		.DEPTH(BYTE_DEPTH)
	) u_byte_ram (
		.clk  (clk),
		.we   (byte_we),
		.waddr(byte_waddr),
		.wdata(s_tdata),
		.re   (byte_re),
		.raddr(byte_raddr),
		.rdata(byte_rdata)
	);

	prq_ram #(
		.WIDTH(LEN_W),
		.DEPTH(QUEUE_SLOTS)
	) u_len_ram (
		.clk  (clk),
		.we   (len_we),
		.waddr(wr_idx_q),
		.wdata(len_wdata),
		.re   (len_re),
		.raddr(rd_idx_q),
		.rdata(len_rdata)
	);

	// control: ring indices, partial packet and pop sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			pend_q    <= '0;
			over_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (s_tuser == OP_PUSH) begin
							if (s_tlast) begin
								pend_q <= '0;
								over_q <= 1'b0;
								if (len_we) begin
									wr_idx_q <= slot_advance(wr_idx_q);
								end
							end else if (room) begin
								pend_q <= pend_q + 1'b1;
							end else begin
								over_q <= 1'b1;
							end
						end else if (s_tuser == OP_POP || s_tuser == OP_PURGE) begin
							if (!is_empty) begin
								rd_idx_q <= slot_advance(rd_idx_q);
							end
							if (!is_empty && s_tuser == OP_POP) begin
								state_q <= S_LEN;
							end
						end
					end
				end
				S_LEN: begin
					state_q <= S_BYTES;
				end
				S_BYTES: begin
					if (out_free && byte_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: pop context and output word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			base_q <= rd_idx_q;
			full_q <= (slot_advance(wr_idx_q) == slot_advance(rd_idx_q));
			m_byte_q <= '0;
			m_last_q <= 1'b1;
			if (s_tuser == OP_PUSH) begin
				if (over_next) begin
					m_status_q <= ST_TOO_LONG;
					m_full_q   <= full_now;
				end else if (full_now) begin
					m_status_q <= ST_FULL;
					m_full_q   <= 1'b1;
				end else begin
					m_status_q <= ST_QUEUED;
					m_full_q   <= (slot_advance(slot_advance(wr_idx_q)) == rd_idx_q);
				end
			end else if (is_empty) begin
				m_status_q <= ST_EMPTY;
				m_full_q   <= full_now;
			end else begin
				m_status_q <= ST_DROPPED;
				m_full_q   <= (slot_advance(wr_idx_q) == slot_advance(rd_idx_q));
			end
		end
		if (state_q == S_LEN) begin
			len_q <= len_rdata;
			off_q <= '0;
		end
		if (state_q == S_BYTES && out_free) begin
			m_status_q <= ST_BYTE;
			m_byte_q   <= byte_rdata;
			m_last_q   <= byte_last;
			m_full_q   <= full_q;
			off_q      <= off_t'(off_q + 1'b1);
		end
	end

	// output ports
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {7'd0, m_full_q, m_byte_q};

endmodule

// ===== dv/packet_ring_queue_checker.sv =====
// packet_ring_queue_checker: watches both streams of the packet ring queue, predicts every
// result word from the accepted input words and compares them in arrival order
// depends on prq_pkg
`timescale 1ns / 1ps

module packet_ring_queue_checker
	import prq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] operation
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] out_byte, [8] queue_full, [15:9] zero
	input  logic [2:0]  m_tuser,   // [2:0] status
	input  logic        m_tlast,   // end_of_packet
	output int          error_count,
	output int          pending_count,
	output int          result_count,
	output int          full_refusals
);

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic       eop;
		logic       full;
	} result_t;

	// results still owed by the queue, oldest first
	result_t    owed_results[$];
	result_t    want;

	// shadow copy of the queue contents and pointers
	logic [7:0] slot_bytes [QUEUE_SLOTS][MAX_PACKET_BYTES];
	len_t       slot_len [QUEUE_SLOTS];
	slot_t      head;
	slot_t      tail;
	len_t       fill;
	logic       overlong;

	function automatic slot_t ring_next(slot_t s);
		return slot_t'((int'(s) + 1) % QUEUE_SLOTS);
	endfunction

	// apply one input word to the shadow queue and queue up what it should produce
	function automatic void predict_word(logic [1:0] op, logic [7:0] b, logic l);
		result_t r;
		slot_t   from;
		int      n;
		int      i;
		logic    full_after;
		r = '0;
		r.eop = 1'b1;
		n = 0;
		from = head;
		case (op)
			OP_PUSH: begin
				if (fill < len_t'(MAX_PACKET_BYTES)) begin
					slot_bytes[tail][fill] = b;
					fill = fill + 1'b1;
				end else begin
					overlong = 1'b1;
				end
				if (!l)
					return;
				// length is judged before room in the ring
				if (overlong) begin
					r.status = ST_TOO_LONG;
				end else if (ring_next(tail) == head) begin
					r.status = ST_FULL;
				end else begin
					slot_len[tail] = fill;
					tail = ring_next(tail);
					r.status = ST_QUEUED;
				end
				fill = '0;
				overlong = 1'b0;
			end
			OP_POP, OP_PURGE: begin
				if (tail == head) begin
					r.status = ST_EMPTY;
				end else begin
					if (op == OP_POP)
						n = int'(slot_len[head]);
					r.status = ST_DROPPED;
					head = ring_next(head);
				end
			end
			default: return;
		endcase
		full_after = (ring_next(tail) == head);
		if (n == 0) begin
			r.full = full_after;
			owed_results.push_back(r);
		end
		for (i = 0; i < n; i++) begin
			r.status = ST_BYTE;
			r.out_byte = slot_bytes[from][i];
			r.eop = (i == n - 1);
			r.full = full_after;
			owed_results.push_back(r);
		end
	endfunction

	task automatic check_field(string name, int expected_v, int actual_v);
		if (expected_v != actual_v) begin
			$error("%s: expected %0d, got %0d", name, expected_v, actual_v);
			error_count++;
		end
	endtask

	initial begin
		error_count = 0;
		pending_count = 0;
		result_count = 0;
		full_refusals = 0;
	end

	// compare the word leaving, then predict from the word entering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			tail = '0;
			fill = '0;
			overlong = 1'b0;
			owed_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				result_count++;
				if (owed_results.size() == 0) begin
					$error("result word with nothing owed: status %0d, data %0h", m_tuser, m_tdata);
					error_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("out_byte", want.out_byte, m_tdata[7:0]);
					check_field("queue_full", want.full, m_tdata[8]);
					check_field("pad", 0, m_tdata[15:9]);
					check_field("end_of_packet", want.eop, m_tlast);
					if (want.status == ST_FULL)
						full_refusals++;
				end
			end
			if (s_tvalid && s_tready)
				predict_word(s_tuser, s_tdata, s_tlast);
		end
		pending_count = owed_results.size();
	end

endmodule

// ===== dv/packet_ring_queue_unit_test.sv =====
// packet_ring_queue_unit_test: drives push, pop and purge words into the packet ring queue
// under varying back-pressure and reports the verdict from packet_ring_queue_checker
// depends on prq_pkg, packet_ring_queue_unit and packet_ring_queue_checker
`timescale 1ns / 1ps

module packet_ring_queue_unit_test;
	import prq_pkg::*;

	localparam logic [1:0] OP_SPARE     = 2'd3;
	localparam int         LIMIT_CYCLES = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int send_gap_pct;
	int recv_stall_pct;
	int words_sent;
	int cycle_count;
	int error_count;
	int pending_count;
	int result_count;
	int full_refusals;

	packet_ring_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	packet_ring_queue_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.error_count   (error_count),
		.pending_count (pending_count),
		.result_count  (result_count),
		.full_refusals (full_refusals)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// offer one word, with random gaps ahead of it, and wait until it is taken
	task automatic send_word(logic [1:0] op, logic [7:0] b, logic l);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// one packet of random bytes; pops or purges may cut into it
	task automatic push_packet(int len, int cut_pct);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < cut_pct)
				send_word($urandom_range(1) ? OP_POP : OP_PURGE, $urandom, $urandom_range(1));
			send_word(OP_PUSH, $urandom, i == len - 1);
		end
	endtask

	// mostly short packets, some at the size limit and some past it
	function automatic int pick_length();
		int r;
		r = $urandom_range(19);
		if (r < 14)
			return $urandom_range(3, 1);
		else if (r < 16)
			return $urandom_range(MAX_PACKET_BYTES - 1, 4);
		else if (r < 18)
			return MAX_PACKET_BYTES;
		return $urandom_range(MAX_PACKET_BYTES + 4, MAX_PACKET_BYTES + 1);
	endfunction

	task automatic run_mix(int actions);
		int r;
		repeat (actions) begin
			r = $urandom_range(99);
			if (r < 35)
				push_packet(pick_length(), 6);
			else if (r < 70)
				send_word(OP_POP, $urandom, $urandom_range(1));
			else if (r < 90)
				send_word(OP_PURGE, $urandom, $urandom_range(1));
			else
				send_word(OP_SPARE, $urandom, $urandom_range(1));
		end
	endtask

	// hold the sender off until every owed result has come out
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_PUSH;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		send_gap_pct = 8;
		recv_stall_pct = 75;
		words_sent = 0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue, unused code, extreme bytes, pop and purge around a partial packet
		send_word(OP_POP, 8'hA5, 1'b1);
		send_word(OP_PURGE, 8'h00, 1'b0);
		send_word(OP_SPARE, 8'hFF, 1'b1);
		send_word(OP_PUSH, 8'h00, 1'b1);
		send_word(OP_PUSH, 8'hFF, 1'b1);
		send_word(OP_PUSH, 8'h81, 1'b0);
		send_word(OP_PUSH, 8'h7E, 1'b0);
		send_word(OP_POP, 8'h55, 1'b0);
		send_word(OP_PURGE, 8'hAA, 1'b1);
		send_word(OP_POP, 8'h00, 1'b1);
		send_word(OP_PUSH, 8'h3C, 1'b1);
		send_word(OP_POP, 8'hFF, 1'b0);
		send_word(OP_PURGE, 8'h0F, 1'b0);

		// fill the ring past capacity so refusals and the full flag show up
		repeat (134) begin
			if ($urandom_range(11) == 0)
				send_word(OP_SPARE, $urandom, $urandom_range(1));
			push_packet(1, 0);
		end
		wait_quiet();
		send_word(OP_PURGE, $urandom, $urandom_range(1));
		push_packet(1, 0);
		push_packet(1, 0);

		// slow sender, eager receiver; size limit and overlong on a full ring first
		send_gap_pct = 75;
		recv_stall_pct = 8;
		push_packet(MAX_PACKET_BYTES, 0);
		push_packet(MAX_PACKET_BYTES + 1, 0);
		run_mix(7);

		// no idling on either side
		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_mix(7);

		wait_quiet();
		repeat (20) @(posedge clk);
		@(negedge clk);
		$display("run drove %0d input words (push, pop, purge, unused code) and checked %0d results",
			words_sent, result_count);
		$display("ring filled and wrapped; %0d pushes refused for a full queue", full_refusals);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
